[sv/sci_pkg.sv]
// sci_pkg: shared types, register indexes and constants for the serial command ID table.
// No dependencies; compile first.
package sci_pkg;

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam int         OVF_LEN      = 9;
	localparam int         QUEUE_DEPTH  = 4;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_DUMP      = 3'd0;
	localparam logic [2:0] REG_FLUSH     = 3'd1;
	localparam logic [2:0] REG_R1_ON     = 3'd2;
	localparam logic [2:0] REG_R2_ON     = 3'd3;
	localparam logic [2:0] REG_R1_OFF    = 3'd4;
	localparam logic [2:0] REG_R2_OFF    = 3'd5;

	typedef struct packed {
		logic [7:0] dump_code;
		logic [7:0] flush_code;
		logic [7:0] relay_one_on_code;
		logic [7:0] relay_two_on_code;
		logic [7:0] relay_one_off_code;
		logic [7:0] relay_two_off_code;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_STATUS,
		KIND_OVERFLOW,
		KIND_DUMP
	} kind_t;

	// one queue entry per accepted byte; state snapshot after that byte
	typedef struct packed {
		kind_t      kind;
		logic       relay_one;
		logic       relay_two;
		logic [2:0] count;
	} entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SHOW
	} back_state_t;

	function automatic logic [7:0] ovf_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0: b = 8'h6f; // o
			4'd1: b = 8'h76; // v
			4'd2: b = 8'h65; // e
			4'd3: b = 8'h72; // r
			4'd4: b = 8'h66; // f
			4'd5: b = 8'h6c; // l
			4'd6: b = 8'h6f; // o
			4'd7: b = 8'h77; // w
			4'd8: b = NEWLINE_BYTE;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[sv/sci_rx_if.sv]
// sci_rx_if: valid/ready channel carrying received bytes.
// No dependencies.
interface sci_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

[sv/sci_tx_if.sv]
// sci_tx_if: valid/ready channel carrying result transactions.
// No dependencies.
interface sci_tx_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       relay_one;
	logic       relay_two;
	logic [2:0] stored_count;
	logic       last;

	modport source (output valid, output tx_valid, output tx_byte, output relay_one,
		output relay_two, output stored_count, output last, input ready);
	modport sink (input valid, input tx_valid, input tx_byte, input relay_one,
		input relay_two, input stored_count, input last, output ready);
endinterface

[sv/serial_command_id_table.sv]
// serial_command_id_table: top level; config registers, front, queue and back.
// Depends on sci_pkg, sci_rx_if, sci_tx_if, sci_fifo, sci_front, sci_back.
//
// channel | dir | payload                                          | note
// --------+-----+--------------------------------------------------+--------------------
// rx      | in  | rx_byte[7:0]                                     | one byte/transaction
// tx      | out | tx_valid, tx_byte[7:0], relay_one, relay_two,    | 1..52 per rx byte,
//         |     | stored_count[2:0], last                          | last on the final one
// apb     | in  | paddr[4:0], pwdata/prdata[31:0]                  | six 8-bit code regs
//
// The front takes one byte per cycle while the 4-entry queue has room.
// The back sends a plain status result from a show state, an overflow
// message from a show state per byte, and a dump from a registered table read
// and a show state per ID character, with a show state alone for each newline.
// The front stops taking bytes from a dump newline until the dump is out.
// Reset (arst_n low) empties line, table count, relays and queue; codes go to
// their defaults. The table memory itself is not cleared.
module serial_command_id_table #(
	parameter int ID_CHARS      = 12,
	parameter int LINE_CHARS    = 16,
	parameter int TABLE_ENTRIES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	sci_rx_if.sink      rx,
	sci_tx_if.source    tx,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sci_pkg::*;

	localparam int ADDR_W = $clog2(TABLE_ENTRIES * ID_CHARS);

	cfg_t              cfg_q;
	logic              cfg_wr;
	logic [2:0]        reg_idx;

	logic              q_push, q_full, q_pop, q_empty;
	entry_t            q_in, q_out;
	logic              dump_done;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;

	// ---- configuration port: write on access phase, always ready
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dump_code          <= 8'd100;
			cfg_q.flush_code         <= 8'd102;
			cfg_q.relay_one_on_code  <= 8'd49;
			cfg_q.relay_two_on_code  <= 8'd50;
			cfg_q.relay_one_off_code <= 8'd51;
			cfg_q.relay_two_off_code <= 8'd52;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DUMP:   cfg_q.dump_code          <= pwdata[7:0];
				REG_FLUSH:  cfg_q.flush_code         <= pwdata[7:0];
				REG_R1_ON:  cfg_q.relay_one_on_code  <= pwdata[7:0];
				REG_R2_ON:  cfg_q.relay_two_on_code  <= pwdata[7:0];
				REG_R1_OFF: cfg_q.relay_one_off_code <= pwdata[7:0];
				REG_R2_OFF: cfg_q.relay_two_off_code <= pwdata[7:0];
				default: ;  // unmapped: ignored
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DUMP:   prdata = {24'd0, cfg_q.dump_code};
			REG_FLUSH:  prdata = {24'd0, cfg_q.flush_code};
			REG_R1_ON:  prdata = {24'd0, cfg_q.relay_one_on_code};
			REG_R2_ON:  prdata = {24'd0, cfg_q.relay_two_on_code};
			REG_R1_OFF: prdata = {24'd0, cfg_q.relay_one_off_code};
			REG_R2_OFF: prdata = {24'd0, cfg_q.relay_two_off_code};
			default:    prdata = 32'd0;
		endcase
	end

	// ---- front: line tracking and command decode, one queue entry per byte
	sci_front #(
		.ID_CHARS      (ID_CHARS),
		.LINE_CHARS    (LINE_CHARS),
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ADDR_W        (ADDR_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg       (cfg_q),
		.q_push    (q_push),
		.q_data    (q_in),
		.q_full    (q_full),
		.dump_done (dump_done),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// ---- queue: decouples decode from result output
	sci_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	// ---- back: ID table and result sequencing
	sci_back #(
		.ID_CHARS      (ID_CHARS),
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ADDR_W        (ADDR_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.dump_done (dump_done),
		.tx        (tx)
	);
endmodule

[sv/sci_fifo.sv]
// sci_fifo: short entry queue between front and back.
// Depends on sci_pkg.
module sci_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sci_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output sci_pkg::entry_t pop_data,
	output logic            empty
);
	import sci_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	entry_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   cnt_q;

	assign full     = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push && !full) wptr_q <= wptr_q + 1'b1;
			if (pop && !empty) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> (cnt_q == (PW+1)'(QUEUE_DEPTH)))
		else $error("fifo count moved while full without pop");
endmodule

[sv/sci_front.sv]
// sci_front: accepts bytes, tracks the line, classifies commands, writes ID bytes.
// Depends on sci_pkg, sci_rx_if.
module sci_front #(
	parameter int ID_CHARS      = 12,
	parameter int LINE_CHARS    = 16,
	parameter int TABLE_ENTRIES = 4,
	parameter int ADDR_W        = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	sci_rx_if.sink            rx,
	input  sci_pkg::cfg_t     cfg,
	output logic              q_push,
	output sci_pkg::entry_t   q_data,
	input  logic              q_full,
	input  logic              dump_done,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [7:0]        wr_data
);
	import sci_pkg::*;

	localparam int POS_W = $clog2(LINE_CHARS + 2);

	logic [POS_W-1:0] pos_q;     // bytes held in line
	logic [POS_W-1:0] zf_q;      // first zero byte position
	logic             zf_vld_q;
	logic [7:0]       first_q;
	logic [2:0]       cnt_q;
	logic             r1_q, r2_q;
	logic             pend_q;    // dump queued or running

	logic             fire;
	logic [POS_W-1:0] k_c;
	logic [7:0]       first_c;
	logic             room_c;
	logic             cnt_d_wr, r1_d, r2_d, set_pend;
	logic [2:0]       cnt_d;
	kind_t            kind_c;

	assign rx.ready = !q_full && !pend_q;
	assign fire     = rx.valid && rx.ready;
	assign room_c   = (cnt_q < 3'(TABLE_ENTRIES));

	// text length ends at first zero; the byte before newline becomes zero
	assign k_c     = zf_vld_q ? zf_q : (pos_q - 1'b1);
	assign first_c = (pos_q == POS_W'(1)) ? 8'h00 : first_q;

	always_comb begin
		kind_c   = KIND_STATUS;
		cnt_d    = cnt_q;
		cnt_d_wr = 1'b0;
		r1_d     = r1_q;
		r2_d     = r2_q;
		set_pend = 1'b0;
		if (rx.rx_byte == NEWLINE_BYTE) begin
			if (pos_q != '0) begin
				if (k_c == POS_W'(ID_CHARS)) begin
					if (room_c) begin
						cnt_d    = cnt_q + 3'd1;
						cnt_d_wr = 1'b1;
					end
				end else if (first_c == cfg.dump_code) begin
					if (cnt_q != '0) begin
						kind_c   = KIND_DUMP;
						set_pend = 1'b1;
					end
				end else if (first_c == cfg.flush_code) begin
					cnt_d    = '0;
					cnt_d_wr = 1'b1;
				end else if (first_c == cfg.relay_one_on_code) begin
					r1_d = 1'b1;
				end else if (first_c == cfg.relay_two_on_code) begin
					r2_d = 1'b1;
				end else if (first_c == cfg.relay_one_off_code) begin
					r1_d = 1'b0;
				end else if (first_c == cfg.relay_two_off_code) begin
					r2_d = 1'b0;
				end
			end
		end else if (pos_q > POS_W'(LINE_CHARS)) begin
			kind_c = KIND_OVERFLOW;
		end
	end

	assign q_push           = fire;
	assign q_data.kind      = kind_c;
	assign q_data.relay_one = r1_d;
	assign q_data.relay_two = r2_d;
	assign q_data.count     = cnt_d;

	// ID bytes go straight into the free slot at the table end
	assign wr_en   = fire && (rx.rx_byte != NEWLINE_BYTE) && (pos_q < POS_W'(ID_CHARS)) && room_c;
	assign wr_addr = ADDR_W'(int'(cnt_q) * ID_CHARS + int'(pos_q));
	assign wr_data = rx.rx_byte;

	always_ff @(posedge clk) begin
		if (fire && rx.rx_byte != NEWLINE_BYTE && pos_q == '0) first_q <= rx.rx_byte;
		if (fire && rx.rx_byte == 8'h00 && !zf_vld_q) zf_q <= pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			zf_vld_q <= 1'b0;
			cnt_q    <= '0;
			r1_q     <= 1'b0;
			r2_q     <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			if (dump_done) pend_q <= 1'b0;
			if (fire) begin
				if (set_pend) pend_q <= 1'b1;
				if (cnt_d_wr) cnt_q <= cnt_d;
				r1_q <= r1_d;
				r2_q <= r2_d;
				if (rx.rx_byte == NEWLINE_BYTE || pos_q > POS_W'(LINE_CHARS)) begin
					pos_q    <= '0;
					zf_vld_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
					if (rx.rx_byte == 8'h00) zf_vld_q <= 1'b1;
				end
			end
		end
	end

	a_pend_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !fire)
		else $error("byte accepted while dump pending");
	a_wr_in_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cnt_q < 3'(TABLE_ENTRIES)))
		else $error("ID write into occupied slot");
endmodule

[sv/sci_back.sv]
// sci_back: holds the ID table, drains queue entries into result transactions.
// Depends on sci_pkg, sci_tx_if.
module sci_back #(
	parameter int ID_CHARS      = 12,
	parameter int TABLE_ENTRIES = 4,
	parameter int ADDR_W        = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  sci_pkg::entry_t   q_data,
	output logic              q_pop,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	output logic              dump_done,
	sci_tx_if.source          tx
);
	import sci_pkg::*;

	localparam int DEPTH  = TABLE_ENTRIES * ID_CHARS;
	localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CHR_W  = $clog2(ID_CHARS + 1);

	logic [7:0]        mem [DEPTH];
	back_state_t       state_q, state_d;
	entry_t            ent_q;
	logic [3:0]        idx_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CHR_W-1:0]  chr_q;
	logic [7:0]        rdata_q;

	logic [2:0]        slot_nx;
	logic              nl_c, last_c, adv;
	logic [ADDR_W-1:0] rd_addr;

	assign slot_nx = {{(3-SLOT_W){1'b0}}, slot_q} + 3'd1;
	assign nl_c    = (chr_q == CHR_W'(ID_CHARS));
	assign rd_addr = ADDR_W'(int'(slot_q) * ID_CHARS + int'(chr_q));

	always_comb begin
		case (ent_q.kind)
			KIND_OVERFLOW: last_c = (idx_q == 4'(OVF_LEN - 1));
			KIND_DUMP:     last_c = nl_c && (slot_nx == ent_q.count);
			default:       last_c = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) state_d = (q_data.kind == KIND_DUMP) ? BK_READ : BK_SHOW;
			end
			BK_READ: state_d = BK_SHOW;
			BK_SHOW: begin
				if (tx.ready) begin
					if (last_c) state_d = BK_IDLE;
					else if (ent_q.kind == KIND_DUMP) begin
						if (nl_c) state_d = BK_READ;
						else if (chr_q + 1'b1 == CHR_W'(ID_CHARS)) state_d = BK_SHOW;
						else state_d = BK_READ;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop           = (state_q == BK_IDLE) && !q_empty;
		tx.valid        = (state_q == BK_SHOW);
		adv             = tx.valid && tx.ready;
		dump_done       = adv && last_c && (ent_q.kind == KIND_DUMP);
		tx.relay_one    = ent_q.relay_one;
		tx.relay_two    = ent_q.relay_two;
		tx.stored_count = ent_q.count;
		tx.last         = last_c;
		case (ent_q.kind)
			KIND_OVERFLOW: begin
				tx.tx_valid = 1'b1;
				tx.tx_byte  = ovf_byte(idx_q);
			end
			KIND_DUMP: begin
				tx.tx_valid = 1'b1;
				tx.tx_byte  = nl_c ? NEWLINE_BYTE : rdata_q;
			end
			default: begin
				tx.tx_valid = 1'b0;
				tx.tx_byte  = 8'h00;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (state_q == BK_READ) rdata_q <= mem[rd_addr];
		if (q_pop) ent_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			slot_q  <= '0;
			chr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				idx_q  <= '0;
				slot_q <= '0;
				chr_q  <= '0;
			end else if (adv && !last_c) begin
				idx_q <= idx_q + 4'd1;
				if (nl_c) begin
					slot_q <= slot_q + 1'b1;
					chr_q  <= '0;
				end else begin
					chr_q <= chr_q + 1'b1;
				end
			end
		end
	end

	a_dump_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE && ent_q.kind == KIND_DUMP) |->
			({{(3-SLOT_W){1'b0}}, slot_q} < ent_q.count))
		else $error("dump slot beyond stored count");
	a_ovf_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SHOW && ent_q.kind == KIND_OVERFLOW) |-> (idx_q < 4'(OVF_LEN)))
		else $error("overflow index out of range");
	a_show_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && !tx.ready) |=> (tx.valid && $stable(tx.tx_byte)))
		else $error("result changed while stalled");
endmodule
